@@ rtl/core/dbscan_pkg.sv @@
// shared types and constants of the density clustering engine
package dbscan_pkg;

  localparam int EPS_W = 35;
  localparam int MINPTS_W = 7;
  localparam int LABEL_W = 6;

  typedef enum logic [1:0] {
    ST_UNVISITED = 2'd0,
    ST_NOISE     = 2'd1,
    ST_MEMBER    = 2'd2
  } pt_status_t;

  localparam logic CFG_IDX_EPS = 1'b0;
  localparam logic CFG_IDX_MINPTS = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic store_pt;     // write the input point at the fill count
    logic clear_set;    // clear status and pending flags, cluster counter
    logic load_a;       // fetch point a (pivot)
    logic load_b;       // fetch point b (scan)
    logic cnt_clear;    // clear neighbour count
    logic cnt_acc;      // accumulate near result of current pair
    logic mark_acc;     // set pending on b if near and not member
    logic open_cluster; // make pivot a member of a new cluster
    logic set_noise;    // mark pivot noise
    logic take_pend;    // pivot from pending: clear flag, join cluster
    logic done_clear;   // reset fill count after emission
  } dbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_core;    // count reaches min_points
    logic [1:0] a_status;   // status of pivot
    logic       pend_any;   // some pending flag set
  } dbs_sts_t;

endpackage

@@ rtl/core/dbscan_datapath.sv @@
// point store, distance unit, status and label storage
module dbscan_datapath import dbscan_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int DIMS = 4,
  parameter int COORD_BITS = 16,
  parameter int IDX_W = $clog2(MAX_POINTS),
  parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dbs_cmd_t                    cmd,
  output dbs_sts_t                    sts,
  input  logic [DIMS*COORD_BITS-1:0]  in_pt,
  input  logic [IDX_W-1:0]            a_idx,
  input  logic [IDX_W-1:0]            b_idx,
  input  logic [IDX_W-1:0]            rd_idx,
  output logic [CNT_W-1:0]            fill_cnt,
  output logic [IDX_W-1:0]            pend_idx,
  output logic [LABEL_W-1:0]          rd_label,
  output logic                        rd_noise,
  input  logic [EPS_W-1:0]            eps_sq,
  input  logic [MINPTS_W-1:0]         min_pts
);
  localparam int PT_W = DIMS * COORD_BITS;
  localparam int SQ_W = 2 * COORD_BITS + 1;
  localparam int SUM_W = SQ_W + 3;

  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [LABEL_W-1:0] label_mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] memb_r, noise_r;
  logic [MAX_POINTS-1:0] pend_r;
  logic [PT_W-1:0] a_pt_r, b_pt_r;
  logic [SQ_W-1:0] sq_r [DIMS];
  logic [CNT_W-1:0] fill_r, cnt_r;
  logic [LABEL_W-1:0] clus_r;
  logic [IDX_W-1:0] bq1_r, bq2_r, bq3_r;
  logic v1_r, v2_r, v3_r, mk1_r, mk2_r, mk3_r, ca1_r, ca2_r, ca3_r, near_r;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (cmd.store_pt && fill_r < CNT_W'(MAX_POINTS))
      mem[fill_r[IDX_W-1:0]] <= in_pt;
    if (cmd.load_a) a_pt_r <= mem[a_idx];
    if (cmd.load_b) b_pt_r <= mem[b_idx];
    // the counter already moved past the open cluster when members join
    if (cmd.open_cluster || cmd.take_pend)
      label_mem[a_idx] <= cmd.take_pend ? clus_r - 1'b1 : clus_r;
    rd_label <= label_mem[rd_idx];
  end

  // stage 1: coordinate squares, stage 2: sum and compare
  always_ff @(posedge clk) begin
    for (int d = 0; d < DIMS; d++) begin
      logic signed [COORD_BITS:0] df;
      logic [COORD_BITS:0] ad;
      df = $signed({a_pt_r[d*COORD_BITS+COORD_BITS-1], a_pt_r[d*COORD_BITS +: COORD_BITS]})
         - $signed({b_pt_r[d*COORD_BITS+COORD_BITS-1], b_pt_r[d*COORD_BITS +: COORD_BITS]});
      ad = df[COORD_BITS] ? (COORD_BITS+1)'(-df) : df;
      sq_r[d] <= SQ_W'(ad) * SQ_W'(ad);
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < DIMS; d++) sum = sum + SUM_W'(sq_r[d]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; near_r <= 1'b0;
      mk1_r <= 1'b0; mk2_r <= 1'b0; mk3_r <= 1'b0;
      ca1_r <= 1'b0; ca2_r <= 1'b0; ca3_r <= 1'b0;
    end else begin
      v1_r <= cmd.load_b; mk1_r <= cmd.mark_acc; ca1_r <= cmd.cnt_acc;
      v2_r <= v1_r; mk2_r <= mk1_r; ca2_r <= ca1_r;
      v3_r <= v2_r; mk3_r <= mk2_r; ca3_r <= ca2_r;
      near_r <= {{(64-SUM_W){1'b0}}, sum} <= {29'd0, eps_sq};
    end
    bq1_r <= b_idx; bq2_r <= bq1_r; bq3_r <= bq2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0; clus_r <= '0; cnt_r <= '0; pend_r <= '0;
      memb_r <= '0; noise_r <= '0;
    end else begin
      if (cmd.store_pt && fill_r < CNT_W'(MAX_POINTS)) fill_r <= fill_r + 1'b1;
      if (cmd.done_clear) fill_r <= '0;
      if (cmd.cnt_clear) cnt_r <= '0;
      else if (v3_r && ca3_r && near_r) cnt_r <= cnt_r + 1'b1;
      if (v3_r && mk3_r && near_r && !memb_r[bq3_r])
        pend_r[bq3_r] <= 1'b1;
      if (cmd.clear_set) begin
        pend_r <= '0; clus_r <= '0;
      end
      if (cmd.take_pend) pend_r[a_idx] <= 1'b0;
      if (cmd.open_cluster) clus_r <= clus_r + 1'b1;
      if (cmd.clear_set) begin
        memb_r <= '0; noise_r <= '0;
      end
      if (cmd.set_noise) noise_r[a_idx] <= 1'b1;
      if (cmd.open_cluster || cmd.take_pend) memb_r[a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_noise <= !memb_r[rd_idx];
  end

  always_comb begin
    pend_idx = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--)
      if (pend_r[i]) pend_idx = IDX_W'(i);
  end

  assign fill_cnt = fill_r;
  assign sts.is_core = {{(MINPTS_W+1-CNT_W){1'b0}}, cnt_r} >= {1'b0, min_pts};
  assign sts.a_status = memb_r[a_idx] ? ST_MEMBER :
                        (noise_r[a_idx] ? ST_NOISE : ST_UNVISITED);
  assign sts.pend_any = |pend_r;
endmodule

@@ rtl/core/dbscan_ctrl.sv @@
// sequencer for loading, clustering and label emission
module dbscan_ctrl import dbscan_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int IDX_W = $clog2(MAX_POINTS),
  parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  output logic              in_rdy,
  output dbs_cmd_t          cmd,
  input  dbs_sts_t          sts,
  input  logic [CNT_W-1:0]  fill_cnt,
  input  logic [IDX_W-1:0]  pend_idx,
  output logic [IDX_W-1:0]  a_idx,
  output logic [IDX_W-1:0]  b_idx,
  output logic [IDX_W-1:0]  rd_idx,
  output logic              o_vld,
  input  logic              o_rdy,
  output logic [IDX_W-1:0]  o_idx,
  output logic              o_last
);
  typedef enum logic [3:0] {
    S_LOAD, S_PIVOT, S_CNT, S_CNT_WAIT, S_DECIDE, S_MARK, S_MARK_WAIT,
    S_PEND, S_PCHK, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state_r;
  logic [IDX_W-1:0] i_r, b_r, e_r;
  logic [CNT_W-1:0] n_r;
  logic exp_r, b_end;
  logic [2:0] wait_r;

  assign b_end = CNT_W'(b_r) == n_r - 1'b1;
  assign in_rdy = state_r == S_LOAD;
  assign b_idx = b_r;
  assign rd_idx = e_r;
  assign o_idx = e_r;
  assign o_last = CNT_W'(e_r) == n_r - 1'b1;

  always_comb begin
    cmd = '0;
    a_idx = exp_r ? pend_idx : i_r;
    cmd.store_pt = in_fire;
    cmd.clear_set = in_fire && in_last;
    case (state_r)
      S_PIVOT: begin
        if (sts.a_status == ST_UNVISITED) begin
          cmd.load_a = 1'b1; cmd.cnt_clear = 1'b1;
        end
      end
      S_CNT: begin
        cmd.load_b = 1'b1; cmd.cnt_acc = 1'b1;
      end
      S_DECIDE: begin
        if (!exp_r) begin
          cmd.open_cluster = sts.is_core;
          cmd.set_noise = !sts.is_core;
        end
      end
      S_MARK: begin
        cmd.load_b = 1'b1; cmd.mark_acc = 1'b1;
      end
      S_PEND: begin
        if (sts.pend_any) begin
          cmd.take_pend = 1'b1;
          if (sts.a_status == ST_UNVISITED) begin
            cmd.load_a = 1'b1; cmd.cnt_clear = 1'b1;
          end
        end
      end
      S_EMIT: cmd.done_clear = o_rdy && o_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; i_r <= '0; b_r <= '0; e_r <= '0; n_r <= '0;
      exp_r <= 1'b0; wait_r <= '0; o_vld <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: if (in_fire && in_last) begin
          n_r <= (fill_cnt < CNT_W'(MAX_POINTS)) ? fill_cnt + 1'b1 : fill_cnt;
          i_r <= '0; exp_r <= 1'b0; state_r <= S_PIVOT;
        end
        S_PIVOT: begin
          if (sts.a_status == ST_UNVISITED) begin
            b_r <= '0; state_r <= S_CNT;
          end else if (CNT_W'(i_r) == n_r - 1'b1) begin
            e_r <= '0; state_r <= S_EMIT_RD;
          end else i_r <= i_r + 1'b1;
        end
        S_CNT: if (b_end) begin
          wait_r <= 3'd3; state_r <= S_CNT_WAIT;
        end else b_r <= b_r + 1'b1;
        S_CNT_WAIT: if (wait_r == 3'd0) state_r <= S_DECIDE;
          else wait_r <= wait_r - 1'b1;
        S_DECIDE: begin
          b_r <= '0;
          if (sts.is_core) state_r <= S_MARK;
          else if (exp_r) state_r <= S_PEND;
          else state_r <= S_PIVOT;
        end
        S_MARK: if (b_end) begin
          wait_r <= 3'd3; state_r <= S_MARK_WAIT;
        end else b_r <= b_r + 1'b1;
        S_MARK_WAIT: if (wait_r == 3'd0) begin
          exp_r <= 1'b1; state_r <= S_PCHK;
        end else wait_r <= wait_r - 1'b1;
        // the idle S_PCHK state lets the pending priority settle
        S_PCHK: state_r <= S_PEND;
        S_PEND: begin
          if (!sts.pend_any) begin
            exp_r <= 1'b0; state_r <= S_PIVOT;
          end else if (sts.a_status == ST_UNVISITED) begin
            b_r <= '0; state_r <= S_CNT;
          end else state_r <= S_PCHK;
        end
        S_EMIT_RD: begin
          o_vld <= 1'b1; state_r <= S_EMIT;
        end
        S_EMIT: if (o_rdy) begin
          o_vld <= 1'b0;
          if (o_last) state_r <= S_LOAD;
          else begin
            e_r <= e_r + 1'b1; state_r <= S_EMIT_RD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ rtl/core/density_clustering_engine.sv @@
// top level of the density clustering engine
// usage:
//   in_ channel: one point per transaction; tdata packs coord_0..coord_3,
//   tuser carries last_point. a point with last_point set starts clustering
//   over all stored points (up to MAX_POINTS; extra points are dropped).
//   out_ channel: one label per stored point in load order; tdata packs
//   point_index, cluster_id, is_noise; tlast carries last_result.
//   cfg_ channel: index 0 epsilon_sq, index 1 min_points, written while idle.
// timing:
//   loading accepts one point per cycle. clustering runs a single pipelined
//   distance unit over point pairs: each point scan steps over all n stored
//   points and then drains the distance pipeline, done once for counting and
//   once for marking per core point, so run time is set by the shared distance unit.
//   each label goes through a label read state, then the output state.
// reset clears control state; status is cleared when clustering starts.
// a stalled receiver holds the current label; input waits until all labels
// are delivered.
module density_clustering_engine import dbscan_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int DIMS = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DIMS*16-1:0]   in_tdata,  // coord_0 .. coord_(DIMS-1), 16 bits each
  input  logic                 in_tuser,  // last_point
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata, // point_index, cluster_id, is_noise, zero fill
  output logic                 out_tlast, // last_result
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data
);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  dbs_cmd_t cmd;
  dbs_sts_t sts;
  logic [EPS_W-1:0] eps_r;
  logic [MINPTS_W-1:0] minp_r;
  logic [DIMS*COORD_BITS-1:0] pt;
  logic [IDX_W-1:0] a_idx, b_idx, rd_idx, pend_idx, o_idx;
  logic [CNT_W-1:0] fill_cnt;
  logic [LABEL_W-1:0] rd_label;
  logic rd_noise, in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0; minp_r <= MINPTS_W'(4);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_EPS) eps_r <= cfg_data[EPS_W-1:0];
      if (cfg_index == CFG_IDX_MINPTS) minp_r <= cfg_data[MINPTS_W-1:0];
    end
  end

  always_comb
    for (int d = 0; d < DIMS; d++)
      pt[d*COORD_BITS +: COORD_BITS] = in_tdata[d*16 +: COORD_BITS];

  assign in_fire = in_tvalid && in_tready;

  dbscan_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk, .rst_n, .in_fire, .in_last(in_tuser), .in_rdy(in_tready), .cmd, .sts,
    .fill_cnt, .pend_idx, .a_idx, .b_idx, .rd_idx, .o_vld(out_tvalid),
    .o_rdy(out_tready), .o_idx, .o_last(out_tlast)
  );

  dbscan_datapath #(.MAX_POINTS(MAX_POINTS), .DIMS(DIMS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_pt(pt), .a_idx, .b_idx, .rd_idx, .fill_cnt,
    .pend_idx, .rd_label, .rd_noise, .eps_sq(eps_r), .min_pts(minp_r)
  );

  assign out_tdata = {3'd0, rd_noise, rd_noise ? 6'd0 : rd_label, 6'(o_idx)};
endmodule

@@ rtl/core/dbscan_checker.sv @@
// port-level checks of the density clustering engine and bind
module dbscan_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input open while emitting");
  a_noise_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:6] == 6'd0)
    else $error("noise label with cluster id");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled label changed");
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("input not reopened after last label");
endmodule

bind density_clustering_engine dbscan_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

@@ tb/testbench.sv @@
// self-checking testbench for the density clustering engine
`timescale 1ns / 1ps

import dbscan_pkg::*;

class label_scoreboard;
  typedef struct {
    logic [5:0] idx;
    logic [5:0] cid;
    logic       noise;
    logic       last;
  } label_t;

  logic signed [15:0] pts [64][4];
  int unsigned npts;
  logic [34:0] eps_sq;
  logic [6:0]  min_pts;
  label_t expected_labels [$];
  int errors;
  int sets_done;
  int labels_seen;

  function void reset_state();
    npts = 0;
    eps_sq = '0;
    min_pts = 7'd4;
    expected_labels.delete();
    errors = 0;
    sets_done = 0;
    labels_seen = 0;
  endfunction

  function void set_reg(logic idx, logic [63:0] value);
    if (idx == CFG_IDX_EPS) eps_sq = value[34:0];
    else min_pts = value[6:0];
  endfunction

  function bit near(int a, int b);
    longint unsigned sum;
    longint diff;
    sum = 0;
    for (int d = 0; d < 4; d++) begin
      diff = longint'(pts[a][d]) - longint'(pts[b][d]);
      sum += longint'(diff * diff);
    end
    return sum <= {29'd0, eps_sq};
  endfunction

  function int near_count(int p);
    int c;
    c = 0;
    for (int q = 0; q < npts; q++) if (near(p, q)) c++;
    return c;
  endfunction

  // note an accepted point; on the last point predict all labels
  function void note_point(logic [63:0] data, logic last);
    pt_status_t st [64];
    bit pend [64];
    logic [5:0] lab [64];
    int clusters;
    bit busy;
    label_t e;
    if (npts < 64) begin
      for (int d = 0; d < 4; d++) pts[npts][d] = data[d*16 +: 16];
      npts++;
    end
    if (!last) return;
    clusters = 0;
    for (int i = 0; i < 64; i++) begin
      st[i] = ST_UNVISITED;
      pend[i] = 0;
      lab[i] = '0;
    end
    for (int i = 0; i < npts; i++) begin
      if (st[i] != ST_UNVISITED) continue;
      if (near_count(i) < min_pts) begin
        st[i] = ST_NOISE;
        continue;
      end
      st[i] = ST_MEMBER;
      lab[i] = clusters[5:0];
      for (int q = 0; q < npts; q++)
        if (st[q] != ST_MEMBER && near(i, q)) pend[q] = 1;
      busy = 1;
      while (busy) begin
        busy = 0;
        for (int j = 0; j < npts; j++) begin
          if (!pend[j]) continue;
          pend[j] = 0;
          busy = 1;
          if (st[j] == ST_NOISE) begin
            st[j] = ST_MEMBER;
            lab[j] = clusters[5:0];
          end else if (st[j] == ST_UNVISITED) begin
            st[j] = ST_MEMBER;
            lab[j] = clusters[5:0];
            if (near_count(j) >= min_pts)
              for (int q = 0; q < npts; q++)
                if (st[q] != ST_MEMBER && near(j, q)) pend[q] = 1;
          end
        end
      end
      clusters++;
    end
    for (int k = 0; k < npts; k++) begin
      e.idx = k[5:0];
      e.noise = (st[k] != ST_MEMBER);
      e.cid = e.noise ? 6'd0 : lab[k];
      e.last = (k + 1 == npts);
      expected_labels = {expected_labels, e};
    end
    npts = 0;
    sets_done++;
  endfunction

  function void check_label(logic [15:0] data, logic last);
    label_t e;
    labels_seen++;
    if (expected_labels.size() == 0) begin
      $error("unexpected label transaction idx=%0d", data[5:0]);
      errors++;
      return;
    end
    e = expected_labels.pop_front();
    if (data[5:0] !== e.idx) begin
      $error("point_index expected %0d actual %0d", e.idx, data[5:0]); errors++;
    end
    if (data[11:6] !== e.cid) begin
      $error("cluster_id expected %0d actual %0d", e.cid, data[11:6]); errors++;
    end
    if (data[12] !== e.noise) begin
      $error("is_noise expected %0d actual %0d", e.noise, data[12]); errors++;
    end
    if (last !== e.last) begin
      $error("last_result expected %0d actual %0d", e.last, last); errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [15:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = CFG_IDX_EPS;
  logic [63:0] cfg_data = '0;

  label_scoreboard labels = new();
  bit calm;   // no idling in the last part
  int points_sent;

  density_clustering_engine uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) labels.check_label(out_tdata, out_tlast);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
    end
  end

  task automatic write_reg(logic idx, logic [63:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    labels.set_reg(idx, value);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // valid stays high after a transaction so points can follow back to back
  task automatic send_point(logic [63:0] data, logic last);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= data;
    in_tuser <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    labels.note_point(data, last);
    points_sent++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 0;
    while (labels.expected_labels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] near_point(logic [63:0] base, int spread);
    logic [63:0] p;
    for (int d = 0; d < 4; d++)
      p[d*16 +: 16] = base[d*16 +: 16] + 16'($urandom_range(0, 2*spread) - spread);
    return p;
  endfunction

  // one data set of clustered points with some outliers
  task automatic random_set(int n, int spread);
    logic [63:0] centers [4];
    logic [63:0] p;
    for (int c = 0; c < 4; c++) centers[c] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) p = {$urandom, $urandom};
      else p = near_point(centers[$urandom_range(0, 3)], spread);
      send_point(p, i == n - 1);
    end
  endtask

  initial begin
    int n;
    labels.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: eps 0, min 4, duplicates form a cluster
    for (int i = 0; i < 5; i++) send_point(64'h0001_0002_0003_0004, 0);
    send_point(64'h7fff_8000_7fff_8000, 1);
    wait_drain();

    // full range: max eps, min zero, coordinate extremes
    write_reg(CFG_IDX_EPS, 64'hffff_fff8_0000_0000 | 64'h7_ffff_ffff);
    write_reg(CFG_IDX_MINPTS, 64'd0);
    send_point(64'h8000_8000_8000_8000, 0);
    send_point(64'h7fff_7fff_7fff_7fff, 0);
    send_point(64'hffff_ffff_ffff_ffff, 1);
    wait_drain();

    // single point, min one
    write_reg(CFG_IDX_MINPTS, 64'd1);
    write_reg(CFG_IDX_EPS, 64'd0);
    send_point(64'h1234_5678_9abc_def0, 1);
    wait_drain();

    // overfull store: 66 points, extra ones dropped, min out of range
    write_reg(CFG_IDX_MINPTS, 64'd127);
    write_reg(CFG_IDX_EPS, 64'd1000);
    for (int i = 0; i < 66; i++) send_point({$urandom, $urandom}, i == 65);
    wait_drain();

    // random data sets with varied settings
    while (points_sent < 355) begin
      if (points_sent > 295) calm = 1;
      case ($urandom_range(0, 3))
        0: write_reg(CFG_IDX_EPS, 64'($urandom_range(0, 200)));
        1: write_reg(CFG_IDX_EPS, 64'($urandom_range(0, 20000)));
        2: write_reg(CFG_IDX_EPS, {$urandom, $urandom});
        default: write_reg(CFG_IDX_EPS, 64'd17179869184);
      endcase
      write_reg(CFG_IDX_MINPTS, 64'($urandom_range(0, 8)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 16);
      random_set(n, $urandom_range(0, 60));
      wait_drain();
    end

    $display("ran %0d points in %0d data sets, %0d labels checked",
             points_sent, labels.sets_done, labels.labels_seen);
    if (labels.errors == 0) $display("density_clustering_engine verification clean");
    else $display("density_clustering_engine verification failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("density_clustering_engine verification failed");
    $finish;
  end
endmodule
